// ----- hdl/mrq_pkg.sv -----
`timescale 1ns / 1ps

package mrq_pkg;

    localparam int REGISTER_COUNT_DEF = 10;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] voltage_raw;
        logic [15:0] current_raw;
        logic [15:0] power_raw;
        logic [15:0] energy_raw;
    } t_out_item;

    // Queue entry: either a request to expand or a finished result
    typedef struct packed {
        logic             is_result;
        logic [7:0]       addr;
        logic [1:0]       status;
        logic [3:0][15:0] regs;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/modbus_rtu_meter_query_engine_top.sv -----
`timescale 1ns / 1ps
// First output passes through the command queue and the back end's single output register;
// request bytes then follow one a cycle while the receiver is ready (8 in all).
// Throughput: one input transaction per cycle while the command queue has room; a start
// occupies the output for its 8 request bytes, every other item for at most one result.
// Reset: synchronous, active low; clears control state, slave address returns to 1.
module modbus_rtu_meter_query_engine_top import mrq_pkg::*; #(
    parameter int REG_COUNT   = REGISTER_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    output logic      o_cfg_ready,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    logic [7:0] r_slave_address;
    logic       push, q_full, q_valid, pop;
    t_cmd       push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slave_address <= i_cfg_data;
        end
    end

    mrq_front #(.REG_COUNT(REG_COUNT)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (r_slave_address),
        .i_valid         (i_in_valid),
        .i_item          (i_in_data),
        .o_ready         (o_in_ready),
        .i_full          (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    mrq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    mrq_back #(.REG_COUNT(REG_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_item      (o_out_data),
        .i_ready     (i_out_ready)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");

    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_RESULT) |->
        (!o_out_data.last && o_out_data.tx_byte == 8'h00))
        else $error("result transaction carries request fields");

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.voltage_raw == 16'h0 && o_out_data.current_raw == 16'h0 &&
         o_out_data.power_raw == 16'h0 && o_out_data.energy_raw == 16'h0))
        else $error("failed query carries register data");

    a_pop_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ----- hdl/mrq_front.sv -----
`timescale 1ns / 1ps

module mrq_front import mrq_pkg::*; #(
    parameter int REG_COUNT = REGISTER_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_slave_address,
    input  logic       i_valid,
    input  t_in_item   i_item,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [7:0] REPLY_LEN = 8'(5 + 2 * REG_COUNT);
    localparam logic [7:0] CRC_LO_IDX = 8'(3 + 2 * REG_COUNT);
    localparam logic [7:0] REG_FIRST = 8'd3;
    localparam logic [7:0] REG_LAST  = 8'd10;

    logic             r_awaiting, n_awaiting;
    logic [7:0]       r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [3:0][15:0] r_regs, n_regs;

    logic [7:0]  reg_off;
    logic [15:0] expected;

    assign o_ready  = !i_full;
    assign reg_off  = r_count - REG_FIRST;
    assign expected = {i_item.rx_byte, r_crc_lo};

    always_comb begin
        n_awaiting = r_awaiting;
        n_count    = r_count;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_regs     = r_regs;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.addr = i_slave_address;
        if (i_valid && o_ready) begin
            unique case (i_item.operation)
                OP_START: begin
                    // drop any pending query and send a fresh request
                    o_push     = 1'b1;
                    n_awaiting = 1'b1;
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                    n_crc_lo   = '0;
                end
                OP_TIMEOUT: begin
                    if (r_awaiting) begin
                        o_push          = 1'b1;
                        o_cmd.is_result = 1'b1;
                        o_cmd.status    = ST_TIMEOUT;
                        n_awaiting      = 1'b0;
                    end
                end
                OP_BYTE: begin
                    if (r_awaiting) begin
                        if (r_count < CRC_LO_IDX) begin
                            n_crc   = crc_byte(r_crc, i_item.rx_byte);
                            n_count = r_count + 8'd1;
                            if (r_count >= REG_FIRST && r_count <= REG_LAST) begin
                                if (!reg_off[0]) begin
                                    n_regs[reg_off[2:1]][15:8] = i_item.rx_byte;
                                end else begin
                                    n_regs[reg_off[2:1]][7:0] = i_item.rx_byte;
                                end
                            end
                        end else if (r_count == CRC_LO_IDX) begin
                            n_crc_lo = i_item.rx_byte;
                            n_count  = r_count + 8'd1;
                        end else begin
                            o_push          = 1'b1;
                            o_cmd.is_result = 1'b1;
                            n_awaiting      = 1'b0;
                            n_count         = '0;
                            if (expected == r_crc) begin
                                o_cmd.status = ST_OK;
                                o_cmd.regs   = r_regs;
                            end else begin
                                o_cmd.status = ST_CRC;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_crc_lo   <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_regs <= n_regs;
    end

    // reply length must cover the four captured registers (bytes 3 to 10)
    if (REPLY_LEN < 8'd13) begin : g_len_check
        $error("register count out of range");
    end

endmodule

// ----- hdl/mrq_queue.sv -----
`timescale 1ns / 1ps

module mrq_queue import mrq_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hdl/mrq_back.sv -----
`timescale 1ns / 1ps

module mrq_back import mrq_pkg::*; #(
    parameter int REG_COUNT = REGISTER_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);

    localparam logic [15:0] RC = 16'(REG_COUNT);
    localparam logic [2:0]  STEP_CRC_LO = 3'd6;
    localparam logic [2:0]  STEP_CRC_HI = 3'd7;

    logic        r_valid, n_valid;
    t_out_item   r_item, n_item;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_crc, n_crc;

    logic        load;
    logic [7:0]  req_byte;
    logic [15:0] crc_in;

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign load    = i_cmd_valid && (!r_valid || i_ready);
    assign crc_in  = (r_step == 3'd0) ? CRC_INIT : r_crc;

    always_comb begin
        case (r_step)
            3'd0:        req_byte = i_cmd.addr;
            3'd1:        req_byte = FUNC_READ_INPUT;
            3'd4:        req_byte = RC[15:8];
            3'd5:        req_byte = RC[7:0];
            STEP_CRC_LO: req_byte = r_crc[7:0];
            STEP_CRC_HI: req_byte = r_crc[15:8];
            default:     req_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_step  = r_step;
        n_crc   = r_crc;
        o_pop   = 1'b0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_item  = '0;
            if (i_cmd.is_result) begin
                o_pop              = 1'b1;
                n_item.kind        = KIND_RESULT;
                n_item.status      = i_cmd.status;
                n_item.voltage_raw = i_cmd.regs[0];
                n_item.current_raw = i_cmd.regs[1];
                n_item.power_raw   = i_cmd.regs[2];
                n_item.energy_raw  = i_cmd.regs[3];
            end else begin
                // walk the request one byte a cycle while the output is taken, CRC folded in as it goes
                n_item.kind    = KIND_TX;
                n_item.tx_byte = req_byte;
                n_item.last    = (r_step == STEP_CRC_HI);
                n_step         = r_step + 3'd1;
                if (r_step < STEP_CRC_LO) begin
                    n_crc = crc_byte(crc_in, req_byte);
                end
                if (r_step == STEP_CRC_HI) begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_crc  <= n_crc;
    end

endmodule

// ----- bench/tb_modbus_rtu_meter_query_engine_top.sv -----
`timescale 1ns / 1ps

module tb_modbus_rtu_meter_query_engine_top;
    import mrq_pkg::*;

    localparam int          REPLY_BYTES   = 5 + 2 * REGISTER_COUNT_DEF;
    localparam logic [15:0] REG_WORDS     = 16'(REGISTER_COUNT_DEF);
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          LIMIT_NS      = 2_000_000;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct packed {
        t_in_item  item;
        logic [7:0] reps;
        t_chk      chk;
        t_out_item want;
    } t_row;

    localparam t_out_item RES_NONE    = '0;
    localparam t_out_item RES_TIMEOUT = '{KIND_RESULT, 8'h00, 1'b0, ST_TIMEOUT,
                                          16'h0, 16'h0, 16'h0, 16'h0};
    localparam t_out_item RES_BADCRC  = '{KIND_RESULT, 8'h00, 1'b0, ST_CRC,
                                          16'h0, 16'h0, 16'h0, 16'h0};

    localparam int DIR_ROWS = 9;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{'{OP_TIMEOUT, 8'h00}, 8'd1,  CHK_NONE,  RES_NONE},
        '{'{OP_BYTE,    8'hFF}, 8'd1,  CHK_NONE,  RES_NONE},
        '{'{OP_UNUSED,  8'h55}, 8'd1,  CHK_NONE,  RES_NONE},
        '{'{OP_START,   8'h00}, 8'd1,  CHK_MODEL, RES_NONE},
        '{'{OP_START,   8'hFF}, 8'd1,  CHK_MODEL, RES_NONE},
        '{'{OP_TIMEOUT, 8'hAA}, 8'd1,  CHK_ONE,   RES_TIMEOUT},
        '{'{OP_START,   8'h00}, 8'd1,  CHK_MODEL, RES_NONE},
        // all-zero reply: CRC field reads 0xFF00, never the running CRC
        '{'{OP_BYTE,    8'h00}, 8'd24, CHK_MODEL, RES_NONE},
        '{'{OP_BYTE,    8'hFF}, 8'd1,  CHK_ONE,   RES_BADCRC}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic [7:0] i_cfg_data;
    logic       o_cfg_ready;
    logic       i_in_valid;
    t_in_item   i_in_data;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_ready = 1'b0;

    // predictor state
    logic [7:0]  cur_addr;
    bit          reply_pending;
    logic [7:0]  reply_count;
    logic [15:0] reply_crc;
    logic [7:0]  crc_lo_seen;
    logic [15:0] meter_regs [4];

    t_out_item pred_out [$];
    t_out_item exp_results [$];

    int mismatch_count = 0;
    int items_used     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit pressure_go    = 1'b0;
    logic stall_hold   = 1'b0;

    modbus_rtu_meter_query_engine_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            r = (r[0] ^ data[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Returns 1 unless the block simply ignores the item
    function automatic bit meter_predict(input t_in_item it);
        logic [7:0]  req [8];
        logic [15:0] crc;
        t_out_item   res;
        bit          used;
        int          slot;
        pred_out.delete();
        used = (it.operation == OP_START) ||
               (reply_pending && (it.operation == OP_BYTE || it.operation == OP_TIMEOUT));
        case (it.operation)
            OP_START: begin
                req[0] = cur_addr;
                req[1] = FUNC_READ_INPUT;
                req[2] = 8'h00;
                req[3] = 8'h00;
                req[4] = REG_WORDS[15:8];
                req[5] = REG_WORDS[7:0];
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++) begin
                    crc = crc16_update(crc, req[i]);
                end
                req[6] = crc[7:0];
                req[7] = crc[15:8];
                for (int i = 0; i < 8; i++) begin
                    res = '0;
                    res.kind    = KIND_TX;
                    res.tx_byte = req[i];
                    res.last    = (i == 7);
                    pred_out.push_back(res);
                end
                reply_pending = 1'b1;
                reply_count   = 8'd0;
                reply_crc     = CRC_INIT;
                crc_lo_seen   = 8'd0;
            end
            OP_TIMEOUT: begin
                if (reply_pending) begin
                    reply_pending = 1'b0;
                    res = '0;
                    res.kind   = KIND_RESULT;
                    res.status = ST_TIMEOUT;
                    pred_out.push_back(res);
                end
            end
            OP_BYTE: begin
                if (reply_pending) begin
                    if (reply_count < REPLY_BYTES - 2) begin
                        reply_crc = crc16_update(reply_crc, it.rx_byte);
                        if (reply_count >= 3 && reply_count <= 10) begin
                            slot = (reply_count - 3) >> 1;
                            if (reply_count[0]) begin
                                meter_regs[slot][15:8] = it.rx_byte;
                            end else begin
                                meter_regs[slot][7:0] = it.rx_byte;
                            end
                        end
                        reply_count = reply_count + 8'd1;
                    end else if (reply_count == REPLY_BYTES - 2) begin
                        crc_lo_seen = it.rx_byte;
                        reply_count = reply_count + 8'd1;
                    end else begin
                        reply_pending = 1'b0;
                        reply_count   = 8'd0;
                        res = '0;
                        res.kind = KIND_RESULT;
                        if ({it.rx_byte, crc_lo_seen} == reply_crc) begin
                            res.status      = ST_OK;
                            res.voltage_raw = meter_regs[0];
                            res.current_raw = meter_regs[1];
                            res.power_raw   = meter_regs[2];
                            res.energy_raw  = meter_regs[3];
                        end else begin
                            res.status = ST_CRC;
                        end
                        pred_out.push_back(res);
                    end
                end
            end
            default: ;
        endcase
        return used;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Result checker and receiver back-pressure
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out_data));
            end else begin
                want = exp_results.pop_front();
                check_field("kind", 16'(o_out_data.kind), 16'(want.kind));
                check_field("tx_byte", 16'(o_out_data.tx_byte), 16'(want.tx_byte));
                check_field("last", 16'(o_out_data.last), 16'(want.last));
                check_field("status", 16'(o_out_data.status), 16'(want.status));
                check_field("voltage_raw", o_out_data.voltage_raw, want.voltage_raw);
                check_field("current_raw", o_out_data.current_raw, want.current_raw);
                check_field("power_raw", o_out_data.power_raw, want.power_raw);
                check_field("energy_raw", o_out_data.energy_raw, want.energy_raw);
            end
        end
        i_out_ready <= !stall_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Long receiver hold-off so the command queue fills and stalls the input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input t_in_item it, input bit use_model);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (meter_predict(it)) items_used++;
        if (use_model) begin
            while (pred_out.size() != 0) exp_results.push_back(pred_out.pop_front());
        end
    endtask

    task automatic write_address(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        // let any item that gives no result work its way through
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_addr = value;
    endtask

    task automatic run_query();
        logic [7:0]  reply [$];
        logic [15:0] crc;
        t_in_item    it;
        int          pick;
        int          dmode;
        int          cut;
        pick = $urandom_range(99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(2))
                    0:       it.operation = OP_UNUSED;
                    1:       it.operation = OP_BYTE;
                    default: it.operation = OP_TIMEOUT;
                endcase
                it.rx_byte = 8'($urandom);
                send_item(it, 1'b1);
            end
        end else begin
            dmode = $urandom_range(9);
            reply.push_back(($urandom_range(3) != 0) ? cur_addr : 8'($urandom));
            reply.push_back(($urandom_range(3) != 0) ? FUNC_READ_INPUT : 8'($urandom));
            reply.push_back(($urandom_range(3) != 0) ? 8'(2 * REGISTER_COUNT_DEF)
                                                     : 8'($urandom));
            for (int i = 0; i < 2 * REGISTER_COUNT_DEF; i++) begin
                reply.push_back(dmode == 0 ? 8'h00 : dmode == 1 ? 8'hFF : 8'($urandom));
            end
            crc = CRC_INIT;
            foreach (reply[i]) crc = crc16_update(crc, reply[i]);
            reply.push_back(crc[7:0]);
            reply.push_back(crc[15:8]);
            if ($urandom_range(3) == 0) begin
                reply[$urandom_range(REPLY_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
            end
            it.operation = OP_START;
            it.rx_byte   = 8'($urandom);
            send_item(it, 1'b1);
            cut = (pick < 70) ? REPLY_BYTES : $urandom_range(REPLY_BYTES - 1);
            it.operation = OP_BYTE;
            for (int i = 0; i < cut; i++) begin
                it.rx_byte = reply[i];
                send_item(it, 1'b1);
            end
            if (pick >= 70 && pick < 88) begin
                it.operation = OP_TIMEOUT;
                it.rx_byte   = 8'($urandom);
                send_item(it, 1'b1);
            end
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int target);
        int first;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first = items_used;
        while (items_used - first < target) run_query();
        // close any open query so the block is idle before the next write
        if (reply_pending) send_item('{OP_TIMEOUT, 8'h00}, 1'b1);
    endtask

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'h00;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        cur_addr      = 8'd1;
        reply_pending = 1'b0;
        reply_count   = 8'd0;
        reply_crc     = CRC_INIT;
        crc_lo_seen   = 8'd0;
        foreach (meter_regs[i]) meter_regs[i] = 16'h0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                send_item(DIRECTED[r].item, DIRECTED[r].chk == CHK_MODEL);
                if (DIRECTED[r].chk == CHK_ONE) exp_results.push_back(DIRECTED[r].want);
            end
        end
        if (reply_pending) send_item('{OP_TIMEOUT, 8'h00}, 1'b1);

        write_address(8'h00);
        run_phase(0, 0, 100);
        write_address(8'hFF);
        run_phase(57, 0, 100);
        write_address(8'($urandom));
        run_phase(0, 57, 100);
        write_address(8'($urandom));
        run_phase(8, 8, 100);
        write_address(8'hA5);
        pressure_go = 1'b1;
        run_phase(0, 0, 80);

        i_in_valid <= 1'b0;
        waited = 0;
        while (exp_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (exp_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      exp_results.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
